>>> hdl/rk4msc_pkg.sv
// Shared types and constants of the three-mass spring chain stepper.
// Holds the stream field widths, register indexes, item codes and sequencer step codes.
// Depends on nothing.
package rk4msc_pkg;

    localparam int FIELD_W    = 32;
    localparam int N_LOAD     = 6;
    localparam int IN_DATA_W  = N_LOAD * FIELD_W;
    localparam int OUT_DATA_W = (N_LOAD + 1) * FIELD_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int DIV_BITS   = 8;

    typedef logic [30:0] t_coef;
    typedef logic [24:0] t_step;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_LC_OVER_M1 = 3'd0;
    localparam t_cfg_idx REG_LC_OVER_M2 = 3'd1;
    localparam t_cfg_idx REG_RC_OVER_M2 = 3'd2;
    localparam t_cfg_idx REG_RC_OVER_M3 = 3'd3;
    localparam t_cfg_idx REG_STEP_SIZE  = 3'd4;

    localparam logic FUNC_STEP = 1'b0;

    localparam logic [3:0] OP_DV1_A = 4'd0;
    localparam logic [3:0] OP_DV1_B = 4'd1;
    localparam logic [3:0] OP_DV2_A = 4'd2;
    localparam logic [3:0] OP_DV2_B = 4'd3;
    localparam logic [3:0] OP_DV2_C = 4'd4;
    localparam logic [3:0] OP_DV3_A = 4'd5;
    localparam logic [3:0] OP_DV3_B = 4'd6;
    localparam logic [3:0] OP_KX1   = 4'd7;
    localparam logic [3:0] OP_KX2   = 4'd8;
    localparam logic [3:0] OP_KX3   = 4'd9;
    localparam logic [3:0] OP_KV1   = 4'd10;
    localparam logic [3:0] OP_KV2   = 4'd11;
    localparam logic [3:0] OP_KV3   = 4'd12;
    localparam logic [3:0] OP_DRAIN = 4'd13;

    localparam logic [1:0] STG_K1 = 2'd0;
    localparam logic [1:0] STG_K2 = 2'd1;
    localparam logic [1:0] STG_K3 = 2'd2;
    localparam logic [1:0] STG_K4 = 2'd3;

endpackage

>>> hdl/rk4_three_mass_spring_chain_step_top.sv
// Three-mass spring chain advanced by one fourth-order Runge-Kutta step per step beat.
// Each of the four slopes runs 13 products through the one shared multiplier, and the final
// division by six resolves eight quotient bits a cycle. One beat is in work at a time: a new
// beat is taken only once the result of the last one has been offered on the output.
// Synchronous active-low reset restores the coefficients, step size, initial state and count.
module rk4_three_mass_spring_chain_step_top #(
    parameter int FRAC_BITS  = 24,
    parameter int WORD_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [rk4msc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rk4msc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // load_x1, load_x2, load_x3, load_v1, load_v2, load_v3 from the lowest bit up
    input  logic [rk4msc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // func
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // pos_one, pos_two, pos_three, vel_one, vel_two, vel_three, steps_done from the lowest bit up
    output logic [rk4msc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int W         = WORD_WIDTH;
    localparam int PW        = W + 33;
    localparam int SW        = W + 3;
    localparam int DW        = W + 2;
    localparam int DIV_STEPS = (W + 2 + rk4msc_pkg::DIV_BITS - 1) / rk4msc_pkg::DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * rk4msc_pkg::DIV_BITS;
    localparam int EXT_W     = (W > rk4msc_pkg::FIELD_W) ? W : rk4msc_pkg::FIELD_W;
    localparam int FW        = rk4msc_pkg::FIELD_W;

    localparam logic signed [PW-1:0] WMAX_X = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] WMIN_X = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

    localparam longint WMAX_L = (longint'(1) <<< (W - 1)) - 1;
    localparam longint X2_RAW = ((longint'(4) <<< FRAC_BITS) + 5) / 10;
    localparam longint X3_RAW = ((longint'(2) <<< FRAC_BITS) + 5) / 10;
    localparam longint X2_RST = (X2_RAW > WMAX_L) ? WMAX_L : X2_RAW;
    localparam longint X3_RST = (X3_RAW > WMAX_L) ? WMAX_L : X3_RAW;

    localparam rk4msc_pkg::t_coef C0_RST = rk4msc_pkg::t_coef'(longint'(1) <<< FRAC_BITS);
    localparam rk4msc_pkg::t_coef C1_RST = rk4msc_pkg::t_coef'(longint'(1) <<< (FRAC_BITS - 1));
    localparam rk4msc_pkg::t_coef C2_RST = rk4msc_pkg::t_coef'(longint'(3) <<< (FRAC_BITS - 2));
    localparam rk4msc_pkg::t_coef C3_RST = rk4msc_pkg::t_coef'(longint'(3) <<< (FRAC_BITS - 1));
    localparam rk4msc_pkg::t_step H_RST  =
        rk4msc_pkg::t_step'(((longint'(1) <<< FRAC_BITS) + 500) / 1000);

    localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMB,
        ST_DSET,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
        logic signed [W-1:0] res;
        if (v > WMAX_X) begin
            res = WMAX_X[W-1:0];
        end else if (v < WMIN_X) begin
            res = WMIN_X[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    t_state                   r_state;
    logic [3:0]               r_op;
    logic [1:0]               r_stage;
    rk4msc_pkg::t_coef        r_coef [4];
    rk4msc_pkg::t_step        r_step;
    logic signed [W-1:0]      r_y    [6];
    logic signed [W-1:0]      r_t    [6];
    logic signed [W-1:0]      r_k    [6];
    logic signed [DW-1:0]     r_dacc [3];
    logic signed [SW-1:0]     r_sum  [6];
    logic signed [PW-1:0]     r_prod;
    logic [DIV_W-1:0]         r_dsh  [6];
    logic [2:0]               r_drem [6];
    logic                     r_dneg [6];
    logic [FW-1:0]            r_cnt;
    logic                     r_m_valid;
    logic [rk4msc_pkg::OUT_DATA_W-1:0] r_m_data;

    logic signed [W-1:0]      mul_a;
    logic [31:0]              mul_b;
    logic signed [PW-1:0]     mul_p;
    logic signed [W-1:0]      prod_sat;
    logic [3:0]               wb_op;
    logic [2:0]               wb_k;
    logic signed [W-1:0]      dsat     [3];
    logic signed [W-1:0]      comb_t   [6];
    logic signed [SW-1:0]     comb_sum [6];
    logic [DIV_W-1:0]         div_mag  [6];
    logic [DIV_W-1:0]         div_sh_nx  [6];
    logic [2:0]               div_rem_nx [6];
    logic signed [W-1:0]      fin_y    [6];
    logic signed [W-1:0]      load_y   [6];
    logic [rk4msc_pkg::OUT_DATA_W-1:0] out_data;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign prod_sat = sat_w(r_prod >>> FRAC_BITS);
    assign wb_op    = r_op - 4'd1;
    assign wb_k     = 3'(wb_op - rk4msc_pkg::OP_KX1);
    assign mul_p    = PW'(mul_a) * PW'($signed({1'b0, mul_b}));

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            dsat[j] = sat_w(PW'(r_dacc[j]));
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            rk4msc_pkg::OP_DV1_A: begin
                mul_a = r_t[1];
                mul_b = 32'(r_coef[0]);
            end
            rk4msc_pkg::OP_DV1_B: begin
                mul_a = r_t[0];
                mul_b = 32'(r_coef[0]);
            end
            rk4msc_pkg::OP_DV2_A: begin
                mul_a = r_t[0];
                mul_b = 32'(r_coef[1]);
            end
            rk4msc_pkg::OP_DV2_B: begin
                mul_a = r_t[1];
                mul_b = 32'(r_coef[1]) + 32'(r_coef[2]);
            end
            rk4msc_pkg::OP_DV2_C: begin
                mul_a = r_t[2];
                mul_b = 32'(r_coef[2]);
            end
            rk4msc_pkg::OP_DV3_A: begin
                mul_a = r_t[1];
                mul_b = 32'(r_coef[3]);
            end
            rk4msc_pkg::OP_DV3_B: begin
                mul_a = r_t[2];
                mul_b = 32'(r_coef[3]);
            end
            rk4msc_pkg::OP_KX1: begin
                mul_a = r_t[3];
                mul_b = 32'(r_step);
            end
            rk4msc_pkg::OP_KX2: begin
                mul_a = r_t[4];
                mul_b = 32'(r_step);
            end
            rk4msc_pkg::OP_KX3: begin
                mul_a = r_t[5];
                mul_b = 32'(r_step);
            end
            rk4msc_pkg::OP_KV1: begin
                mul_a = dsat[0];
                mul_b = 32'(r_step);
            end
            rk4msc_pkg::OP_KV2: begin
                mul_a = dsat[1];
                mul_b = 32'(r_step);
            end
            rk4msc_pkg::OP_KV3: begin
                mul_a = dsat[2];
                mul_b = 32'(r_step);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Stage combination: running weighted sum of slopes and the next evaluation point.
    always_comb begin : p_comb
        logic signed [W:0]    kr;
        logic signed [W:0]    kh;
        logic signed [SW-1:0] ks;
        for (int i = 0; i < 6; i++) begin
            kr = (W+1)'(r_k[i]);
            if (r_k[i][W-1]) begin
                kr = kr + (W+1)'(1);
            end
            kh = kr >>> 1;
            ks = SW'(r_k[i]);
            case (r_stage)
                rk4msc_pkg::STG_K1: begin
                    comb_sum[i] = ks;
                    comb_t[i]   = sat_w(PW'(r_y[i]) + PW'(kh));
                end
                rk4msc_pkg::STG_K2: begin
                    comb_sum[i] = r_sum[i] + (ks <<< 1);
                    comb_t[i]   = sat_w(PW'(r_y[i]) + PW'(kh));
                end
                rk4msc_pkg::STG_K3: begin
                    comb_sum[i] = r_sum[i] + (ks <<< 1);
                    comb_t[i]   = sat_w(PW'(r_y[i]) + PW'(r_k[i]));
                end
                default: begin
                    comb_sum[i] = r_sum[i] + ks;
                    comb_t[i]   = r_t[i];
                end
            endcase
        end
    end

    // Division of the slope sum magnitude by six, eight restoring steps a cycle per lane.
    always_comb begin : p_div
        logic [2:0]       rem;
        logic [3:0]       cat;
        logic [DIV_W-1:0] sh;
        logic [SW-1:0]    mag;
        for (int i = 0; i < 6; i++) begin
            mag        = r_sum[i][SW-1] ? SW'(-r_sum[i]) : SW'(r_sum[i]);
            div_mag[i] = DIV_W'(mag[W+1:0]);
            rem        = r_drem[i];
            sh         = r_dsh[i];
            for (int j = 0; j < rk4msc_pkg::DIV_BITS; j++) begin
                cat = {rem, sh[DIV_W-1]};
                sh  = {sh[DIV_W-2:0], 1'b0};
                if (cat >= 4'd6) begin
                    rem   = 3'(cat - 4'd6);
                    sh[0] = 1'b1;
                end else begin
                    rem = cat[2:0];
                end
            end
            div_sh_nx[i]  = sh;
            div_rem_nx[i] = rem;
        end
    end

    always_comb begin : p_fin
        logic signed [W:0]       qs;
        logic signed [EXT_W-1:0] ext;
        for (int i = 0; i < 6; i++) begin
            qs        = $signed({1'b0, r_dsh[i][W-1:0]});
            fin_y[i]  = r_dneg[i] ? sat_w(PW'(r_y[i]) - PW'(qs))
                                  : sat_w(PW'(r_y[i]) + PW'(qs));
            load_y[i] = sat_w(PW'($signed(s_axis_tdata[i*FW +: FW])));
            ext       = EXT_W'(r_y[i]);
            out_data[i*FW +: FW] = ext[FW-1:0];
        end
        out_data[6*FW +: FW] = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_op      <= '0;
            r_stage   <= rk4msc_pkg::STG_K1;
            r_m_valid <= 1'b0;
            r_coef[0] <= C0_RST;
            r_coef[1] <= C1_RST;
            r_coef[2] <= C2_RST;
            r_coef[3] <= C3_RST;
            r_step    <= H_RST;
            r_y[0]    <= '0;
            r_y[1]    <= W'(X2_RST);
            r_y[2]    <= W'(X3_RST);
            r_y[3]    <= '0;
            r_y[4]    <= '0;
            r_y[5]    <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    rk4msc_pkg::REG_LC_OVER_M1: r_coef[0] <= i_cfg_wdata;
                    rk4msc_pkg::REG_LC_OVER_M2: r_coef[1] <= i_cfg_wdata;
                    rk4msc_pkg::REG_RC_OVER_M2: r_coef[2] <= i_cfg_wdata;
                    rk4msc_pkg::REG_RC_OVER_M3: r_coef[3] <= i_cfg_wdata;
                    rk4msc_pkg::REG_STEP_SIZE:  r_step    <= i_cfg_wdata[24:0];
                    default: ;
                endcase
            end

            if (r_m_valid && m_axis_tready && r_state != ST_OUT) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser == rk4msc_pkg::FUNC_STEP) begin
                            for (int i = 0; i < 6; i++) begin
                                r_t[i] <= r_y[i];
                            end
                            r_op    <= '0;
                            r_stage <= rk4msc_pkg::STG_K1;
                            r_state <= ST_MUL;
                        end else begin
                            for (int i = 0; i < 6; i++) begin
                                r_y[i] <= load_y[i];
                            end
                            r_cnt   <= '0;
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_MUL: begin
                    if (r_op != rk4msc_pkg::OP_DRAIN) begin
                        r_prod <= mul_p;
                    end
                    if (r_op != rk4msc_pkg::OP_DV1_A) begin
                        case (wb_op) inside
                            rk4msc_pkg::OP_DV1_A: r_dacc[0] <= DW'(prod_sat);
                            rk4msc_pkg::OP_DV1_B: r_dacc[0] <= r_dacc[0] - DW'(prod_sat);
                            rk4msc_pkg::OP_DV2_A: r_dacc[1] <= DW'(prod_sat);
                            rk4msc_pkg::OP_DV2_B: r_dacc[1] <= r_dacc[1] - DW'(prod_sat);
                            rk4msc_pkg::OP_DV2_C: r_dacc[1] <= r_dacc[1] + DW'(prod_sat);
                            rk4msc_pkg::OP_DV3_A: r_dacc[2] <= DW'(prod_sat);
                            rk4msc_pkg::OP_DV3_B: r_dacc[2] <= r_dacc[2] - DW'(prod_sat);
                            [rk4msc_pkg::OP_KX1:rk4msc_pkg::OP_KV3]: r_k[wb_k] <= prod_sat;
                            default: ;
                        endcase
                    end
                    if (r_op == rk4msc_pkg::OP_DRAIN) begin
                        r_state <= ST_COMB;
                    end else begin
                        r_op <= r_op + 4'd1;
                    end
                end
                ST_COMB: begin
                    for (int i = 0; i < 6; i++) begin
                        r_sum[i] <= comb_sum[i];
                    end
                    if (r_stage == rk4msc_pkg::STG_K4) begin
                        r_state <= ST_DSET;
                    end else begin
                        for (int i = 0; i < 6; i++) begin
                            r_t[i] <= comb_t[i];
                        end
                        r_stage <= r_stage + 2'd1;
                        r_op    <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_DSET: begin
                    for (int i = 0; i < 6; i++) begin
                        r_dsh[i]  <= div_mag[i];
                        r_drem[i] <= '0;
                        r_dneg[i] <= r_sum[i][SW-1];
                    end
                    r_op    <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    for (int i = 0; i < 6; i++) begin
                        r_dsh[i]  <= div_sh_nx[i];
                        r_drem[i] <= div_rem_nx[i];
                    end
                    if (r_op == DIV_LAST) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_op <= r_op + 4'd1;
                    end
                end
                ST_FIN: begin
                    for (int i = 0; i < 6; i++) begin
                        r_y[i] <= fin_y[i];
                    end
                    r_cnt   <= r_cnt + 32'd1;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_data  <= out_data;
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
